/* rtl/pnfe_pkg.sv */
// Package for the Petri net fire unit: payload structs, opcodes,
// register indexes and default sizes. No dependencies.
package pnfe_pkg;

	localparam int unsigned DEF_MAX_PLACES      = 128;
	localparam int unsigned DEF_MAX_TRANSITIONS = 128;
	localparam int unsigned DEF_TOKEN_BITS      = 16;
	localparam int unsigned DEF_WEIGHT_BITS     = 8;

	localparam logic [2:0] OP_SET_TOKENS = 3'd0;
	localparam logic [2:0] OP_SET_IN_W   = 3'd1;
	localparam logic [2:0] OP_SET_OUT_W  = 3'd2;
	localparam logic [2:0] OP_FIRE       = 3'd3;
	localparam logic [2:0] OP_READ       = 3'd4;

	localparam logic [7:0] REG_NUM_PLACES      = 8'd0;
	localparam logic [7:0] REG_NUM_TRANSITIONS = 8'd1;

	typedef struct packed {
		logic [2:0]  opcode;
		logic [6:0]  place_index;
		logic [6:0]  transition_index;
		logic [15:0] value;
	} in_item_t;

	typedef struct packed {
		logic        fired;
		logic [6:0]  fired_transition;
		logic [15:0] token_count;
		logic        overflow;
	} out_item_t;

endpackage

/* rtl/petri_net_first_enabled_fire_unit.sv */
// Petri net fire unit top level: token memory, packed arc weight memory
// and the scan/fire sequencer. Depends on pnfe_pkg.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+---------------------------
//  in      | in        | in_valid/in_stall  | in_data   (in_item_t)
//  out     | out       | out_valid/out_stall| out_data  (out_item_t)
//  cfg     | in        | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// Path to a result beat: token loads and unknown opcodes go straight
// to the result state; weight loads pass through a read-modify-write
// state and reads through a token read state. A fire tests each place
// with one token/weight memory read plus compare, the scan stopping at
// the first failing place, then does a read-modify-write of each active
// place on the token memory.
// Reset: a clearing pass zeroes the weight memory (and the token memory
// alongside); no beat is taken then.
// Stalls: one finished result may wait in the output register while the
// next beat is accepted; a second result waits until that one drains.
module petri_net_first_enabled_fire_unit #(
	parameter int unsigned MAX_PLACES      = pnfe_pkg::DEF_MAX_PLACES,
	parameter int unsigned MAX_TRANSITIONS = pnfe_pkg::DEF_MAX_TRANSITIONS,
	parameter int unsigned TOKEN_BITS      = pnfe_pkg::DEF_TOKEN_BITS,
	parameter int unsigned WEIGHT_BITS     = pnfe_pkg::DEF_WEIGHT_BITS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  pnfe_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output pnfe_pkg::out_item_t out_data,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [7:0]          cfg_index,
	input  logic [7:0]          cfg_data
);
	import pnfe_pkg::*;

	localparam int unsigned ARC_COUNT = MAX_PLACES * MAX_TRANSITIONS;
	localparam int unsigned ARC_W = (ARC_COUNT > 1) ? $clog2(ARC_COUNT) : 1;
	localparam int unsigned PW    = $clog2(MAX_PLACES);
	localparam int unsigned QW    = $clog2(MAX_PLACES + 1);
	localparam int unsigned TW    = $clog2(MAX_TRANSITIONS + 1);
	localparam int unsigned WW    = 2 * WEIGHT_BITS;
	localparam logic [32:0] TOP   = (33'd1 << TOKEN_BITS) - 33'd1;
	localparam logic [32:0] TOP16 = 33'h0_0000_FFFF;

	typedef enum logic [3:0] {
		ST_CLR, ST_IDLE, ST_WLD, ST_TRD, ST_CHK_RD, ST_CHK_EV,
		ST_FIR_RD, ST_FIR_WR, ST_DONE
	} state_t;

	state_t            state_q;
	logic [ARC_W-1:0]  clr_q;
	logic [7:0]        nump_q, numt_q;
	in_item_t          req_q;
	logic              ok_q;
	logic [ARC_W-1:0]  ld_addr_q;
	logic [ARC_W-1:0]  base_q;
	logic [QW-1:0]     q_q;
	logic [TW-1:0]     x_q;
	out_item_t         res_q;
	out_item_t         out_q;
	logic              out_valid_q;

	// memories
	logic [TOKEN_BITS-1:0] tok_mem [MAX_PLACES];
	logic [WW-1:0]         w_mem   [ARC_COUNT];
	logic [TOKEN_BITS-1:0] tok_rd, tok_wd;
	logic [PW-1:0]         tok_ra, tok_wa;
	logic                  tok_we;
	logic [WW-1:0]         w_rd, w_wd;
	logic [ARC_W-1:0]      w_ra, w_wa;
	logic                  w_we;

	// clamped counts and request decode
	logic [QW-1:0]        np;
	logic [TW-1:0]        nt;
	logic                 acc;
	logic [31:0]          p32, t32, q32, x32, clr32;
	logic                 p_ok, t_ok;
	logic [ARC_W-1:0]     ld_addr;
	logic [32:0]          v33, ld_tok33, rd33, win33, wout33, tok33, sum33;
	logic                 out_free;

	always_comb begin
		if (nump_q == 8'd0)
			np = QW'(1);
		else if (32'(nump_q) > MAX_PLACES)
			np = QW'(MAX_PLACES);
		else
			np = QW'(nump_q);
		if (numt_q == 8'd0)
			nt = TW'(1);
		else if (32'(numt_q) > MAX_TRANSITIONS)
			nt = TW'(MAX_TRANSITIONS);
		else
			nt = TW'(numt_q);
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign acc       = in_valid && !in_stall;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign out_free  = !out_valid_q || !out_stall;

	assign p32     = 32'(in_data.place_index);
	assign t32     = 32'(in_data.transition_index);
	assign q32     = 32'(q_q);
	assign x32     = 32'(x_q);
	assign clr32   = 32'(clr_q);
	assign p_ok    = p32 < 32'(np);
	assign t_ok    = t32 < 32'(nt);
	assign ld_addr = ARC_W'(t32 * MAX_PLACES + p32);
	assign v33     = 33'(in_data.value);
	assign ld_tok33 = (v33 > TOP) ? TOP : v33;
	assign rd33    = (33'(tok_rd) > TOP16) ? TOP16 : 33'(tok_rd);

	// weight word layout: {input weight, output weight}
	assign win33  = 33'(w_rd[WW-1:WEIGHT_BITS]);
	assign wout33 = 33'(w_rd[WEIGHT_BITS-1:0]);
	assign tok33  = 33'(tok_rd);
	assign sum33  = tok33 - win33 + wout33;   // enabled: never below zero

	// memory address / write control
	always_comb begin
		tok_ra = q_q[PW-1:0];
		w_ra   = base_q + ARC_W'(q_q);
		tok_we = 1'b0;
		tok_wa = q_q[PW-1:0];
		tok_wd = '0;
		w_we   = 1'b0;
		w_wa   = ld_addr_q;
		w_wd   = '0;
		unique case (state_q)
			ST_CLR: begin
				w_we   = 1'b1;
				w_wa   = clr_q;
				tok_we = clr32 < MAX_PLACES;
				tok_wa = clr_q[PW-1:0];
			end
			ST_IDLE: begin
				tok_ra = p32[PW-1:0];
				w_ra   = ld_addr;
				tok_we = acc && (in_data.opcode == OP_SET_TOKENS) && p_ok;
				tok_wa = p32[PW-1:0];
				tok_wd = ld_tok33[TOKEN_BITS-1:0];
			end
			ST_WLD: begin
				w_we = ok_q;
				if (req_q.opcode == OP_SET_IN_W)
					w_wd = {req_q.value[WEIGHT_BITS-1:0], w_rd[WEIGHT_BITS-1:0]};
				else
					w_wd = {w_rd[WW-1:WEIGHT_BITS], req_q.value[WEIGHT_BITS-1:0]};
			end
			ST_FIR_WR: begin
				tok_we = 1'b1;
				tok_wd = (sum33 > TOP) ? TOP[TOKEN_BITS-1:0] : sum33[TOKEN_BITS-1:0];
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (tok_we)
			tok_mem[tok_wa] <= tok_wd;
		tok_rd <= tok_mem[tok_ra];
	end

	always_ff @(posedge clk) begin
		if (w_we)
			w_mem[w_wa] <= w_wd;
		w_rd <= w_mem[w_ra];
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLR;
			clr_q       <= '0;
			nump_q      <= 8'd128;
			numt_q      <= 8'd128;
			req_q       <= '0;
			ok_q        <= 1'b0;
			ld_addr_q   <= '0;
			base_q      <= '0;
			q_q         <= '0;
			x_q         <= '0;
			res_q       <= '0;
			out_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_NUM_PLACES)
					nump_q <= cfg_data;
				else if (cfg_index == REG_NUM_TRANSITIONS)
					numt_q <= cfg_data;
			end
			// in ST_DONE the output slot is either reloaded or still stalled
			if (out_valid_q && !out_stall && state_q != ST_DONE)
				out_valid_q <= 1'b0;

			unique case (state_q)
				ST_CLR: begin
					clr_q <= clr_q + ARC_W'(1);
					if (clr32 == ARC_COUNT - 1)
						state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (acc) begin
						req_q     <= in_data;
						ok_q      <= p_ok && t_ok;
						ld_addr_q <= ld_addr;
						res_q     <= '0;
						base_q    <= '0;
						q_q       <= '0;
						x_q       <= '0;
						priority case (in_data.opcode)
							OP_SET_IN_W, OP_SET_OUT_W: state_q <= ST_WLD;
							OP_FIRE:                   state_q <= ST_CHK_RD;
							OP_READ:                   state_q <= ST_TRD;
							default:                   state_q <= ST_DONE;
						endcase
					end
				end
				ST_WLD:
					state_q <= ST_DONE;
				ST_TRD: begin
					if (32'(req_q.place_index) < 32'(np))
						res_q.token_count <= rd33[15:0];
					state_q <= ST_DONE;
				end
				ST_CHK_RD:
					state_q <= ST_CHK_EV;
				ST_CHK_EV: begin
					if (win33 > tok33) begin
						// not enabled: move to next transition row
						q_q <= '0;
						if (x32 + 1 == 32'(nt)) begin
							state_q <= ST_DONE;
						end else begin
							x_q     <= x_q + TW'(1);
							base_q  <= base_q + ARC_W'(MAX_PLACES);
							state_q <= ST_CHK_RD;
						end
					end else if (q32 + 1 == 32'(np)) begin
						q_q     <= '0;
						state_q <= ST_FIR_RD;
					end else begin
						q_q     <= q_q + QW'(1);
						state_q <= ST_CHK_RD;
					end
				end
				ST_FIR_RD:
					state_q <= ST_FIR_WR;
				ST_FIR_WR: begin
					if (sum33 > TOP)
						res_q.overflow <= 1'b1;
					if (q32 + 1 == 32'(np)) begin
						res_q.fired            <= 1'b1;
						res_q.fired_transition <= x32[6:0];
						state_q                <= ST_DONE;
					end else begin
						q_q     <= q_q + QW'(1);
						state_q <= ST_FIR_RD;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						out_q       <= res_q;
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default:
					state_q <= ST_IDLE;
			endcase
		end
	end

	// scan and fire never step past the active places or transitions
	a_q_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CHK_EV || state_q == ST_FIR_WR) |-> (q32 < 32'(np)))
		else $error("place counter past active range");

	a_x_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CHK_EV) |-> (x32 < 32'(nt)))
		else $error("transition counter past active range");

	// a fire result never carries a token count
	a_res_excl: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.fired) |-> (out_data.token_count == 16'd0))
		else $error("fire result with token count");

	// overflow only reported alongside a firing
	a_ovf_fired: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.overflow) |-> out_data.fired)
		else $error("overflow without firing");

	// a result beat is only loaded when the output slot is free
	a_no_clobber: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && out_valid_q && out_stall) |=> (state_q == ST_DONE))
		else $error("result left pending state while output blocked");

endmodule

/* tb/petri_net_first_enabled_fire_unit_test.sv */
// Testbench for petri_net_first_enabled_fire_unit: a token/arc predictor in a small
// scoreboard class, directed and random command beats, and random stalls on both sides.
// Depends on pnfe_pkg and the RTL top level only.
`timescale 1ns / 1ps

module petri_net_first_enabled_fire_unit_test;
	import pnfe_pkg::*;

	class pn_scoreboard;
		logic [15:0] tokens [128];
		logic [7:0]  in_w   [128][128];
		logic [7:0]  out_w  [128][128];
		logic [7:0]  places_reg;
		logic [7:0]  trans_reg;
		out_item_t   expected_q [$];
		int          mismatches;

		function new();
			for (int p = 0; p < 128; p++) begin
				tokens[p] = '0;
				for (int t = 0; t < 128; t++) begin
					in_w[t][p]  = '0;
					out_w[t][p] = '0;
				end
			end
			places_reg = 8'd128;
			trans_reg  = 8'd128;
			mismatches = 0;
		endfunction

		// 0 behaves as 1, anything above 128 as 128
		function int active(logic [7:0] r);
			if (r == 0) return 1;
			if (r > 128) return 128;
			return int'(r);
		endfunction

		function void write_reg(logic [7:0] idx, logic [7:0] d);
			if (idx == REG_NUM_PLACES) places_reg = d;
			else if (idx == REG_NUM_TRANSITIONS) trans_reg = d;
		endfunction

		function int n_places();
			return active(places_reg);
		endfunction

		function int n_trans();
			return active(trans_reg);
		endfunction

		// apply one command beat and queue the result it must produce
		function void note_command(in_item_t c);
			out_item_t r;
			int np, nt, s;
			bit ok;
			r = '0;
			np = active(places_reg);
			nt = active(trans_reg);
			case (c.opcode)
				OP_SET_TOKENS:
					if (c.place_index < np) tokens[c.place_index] = c.value;
				OP_SET_IN_W:
					if (c.place_index < np && c.transition_index < nt)
						in_w[c.transition_index][c.place_index] = c.value[7:0];
				OP_SET_OUT_W:
					if (c.place_index < np && c.transition_index < nt)
						out_w[c.transition_index][c.place_index] = c.value[7:0];
				OP_FIRE:
					for (int t = 0; t < nt; t++) begin
						ok = 1;
						for (int p = 0; p < np; p++)
							if (in_w[t][p] > tokens[p]) ok = 0;
						if (ok) begin
							for (int p = 0; p < np; p++) begin
								s = int'(tokens[p]) - int'(in_w[t][p]) + int'(out_w[t][p]);
								if (s > 65535) begin
									s = 65535;
									r.overflow = 1'b1;
								end
								tokens[p] = s[15:0];
							end
							r.fired = 1'b1;
							r.fired_transition = t[6:0];
							break;
						end
					end
				OP_READ:
					if (c.place_index < np) r.token_count = tokens[c.place_index];
				default: ;
			endcase
			expected_q.push_back(r);
		endfunction

		function void check_result(out_item_t got);
			out_item_t e;
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result beat %h", got);
				return;
			end
			e = expected_q.pop_front();
			if (got.fired !== e.fired || got.fired_transition !== e.fired_transition ||
					got.token_count !== e.token_count || got.overflow !== e.overflow) begin
				mismatches++;
				if (mismatches <= 10)
					$display({"mismatch: exp fired=%0d t=%0d cnt=%0d ovf=%0d",
						" got fired=%0d t=%0d cnt=%0d ovf=%0d"},
						e.fired, e.fired_transition, e.token_count, e.overflow,
						got.fired, got.fired_transition, got.token_count, got.overflow);
			end
		endfunction

		function int pending();
			return expected_q.size();
		endfunction
	endclass

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	in_item_t   in_data;
	logic       out_valid;
	logic       out_stall;
	out_item_t  out_data;
	logic       cfg_valid;
	logic       cfg_ready;
	logic [7:0] cfg_index;
	logic [7:0] cfg_data;

	pn_scoreboard sb;
	int  sent;           // command beats accepted so far
	int  send_gap_pct;   // chance the sender idles before a beat
	int  recv_stall_pct; // chance the receiver stalls in a cycle
	longint cycles;
	localparam longint CYCLE_LIMIT = 4000000;

	petri_net_first_enabled_fire_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// every input known from time zero
	initial begin
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		in_data   = '0;
		out_stall = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		sb = new();
		sent = 0;
		send_gap_pct = 6;
		recv_stall_pct = 56;
	end

	// idle profile: light sender gaps and heavy stalls, then the reverse, then none
	always @(posedge clk) begin
		if (sent < 300) begin
			send_gap_pct <= 6;
			recv_stall_pct <= 56;
		end else if (sent < 600) begin
			send_gap_pct <= 56;
			recv_stall_pct <= 6;
		end else begin
			send_gap_pct <= 0;
			recv_stall_pct <= 0;
		end
	end

	always @(posedge clk)
		out_stall <= ($urandom_range(0, 99) < recv_stall_pct);

	// monitor: both handshakes sampled on the edge, before any NBA lands
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				sb.note_command(in_data);
				sent <= sent + 1;
			end
			if (out_valid && !out_stall) sb.check_result(out_data);
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end
	initial cycles = 0;

	// one command beat, held until accepted; valid stays high between back-to-back beats
	task automatic send_beat(in_item_t c);
		int gap;
		gap = ($urandom_range(0, 99) < send_gap_pct) ? $urandom_range(1, 4) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= c;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic cmd(logic [2:0] op, int p, int t, int v);
		in_item_t c;
		c.opcode = op;
		c.place_index = p[6:0];
		c.transition_index = t[6:0];
		c.value = v[15:0];
		send_beat(c);
	endtask

	// drain everything, then write both size registers while the block sits idle
	task automatic set_sizes(int np, int nt);
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= REG_NUM_PLACES;
		cfg_data  <= np[7:0];
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(REG_NUM_PLACES, np[7:0]);
		cfg_index <= REG_NUM_TRANSITIONS;
		cfg_data  <= nt[7:0];
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(REG_NUM_TRANSITIONS, nt[7:0]);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// mostly in-range indexes and small counts so fires actually enable
	task automatic random_beat();
		in_item_t c;
		int np, nt, k;
		np = sb.n_places();
		nt = sb.n_trans();
		k = $urandom_range(0, 99);
		c.place_index = 7'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 127)
			: $urandom_range(0, (np < 127) ? np : 127));
		c.transition_index = 7'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 127)
			: $urandom_range(0, (nt < 127) ? nt : 127));
		if (k < 24) begin
			c.opcode = OP_SET_TOKENS;
			c.value = 16'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 65535)
				: $urandom_range(0, 12));
		end else if (k < 44) begin
			c.opcode = OP_SET_IN_W;
			c.value = 16'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535)
				: $urandom_range(0, 4));
		end else if (k < 62) begin
			c.opcode = OP_SET_OUT_W;
			c.value = 16'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535)
				: $urandom_range(0, 4));
		end else if (k < 84) begin
			c.opcode = OP_FIRE;
			c.value = 16'($urandom_range(0, 65535));
		end else if (k < 97) begin
			c.opcode = OP_READ;
			c.value = 16'($urandom_range(0, 65535));
		end else begin
			c.opcode = 3'($urandom_range(5, 7));
			c.value = 16'($urandom_range(0, 65535));
		end
		send_beat(c);
	endtask

	initial begin
		int np, nt;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: full sizes, extremes, every opcode
		set_sizes(128, 128);
		cmd(OP_READ, 127, 0, 0);              // cleared token memory
		cmd(OP_FIRE, 0, 0, 0);                // no input arcs: transition 0 fires
		cmd(OP_SET_TOKENS, 127, 0, 65535);
		cmd(OP_SET_TOKENS, 0, 0, 0);
		cmd(OP_SET_IN_W, 0, 0, 1);            // transition 0 now starved on place 0
		cmd(OP_SET_OUT_W, 127, 1, 16'hFFFF);  // weight keeps only low byte
		cmd(OP_FIRE, 0, 0, 0);                // transition 1 fires and saturates
		cmd(OP_READ, 127, 0, 0);
		cmd(OP_SET_IN_W, 0, 1, 1);
		cmd(OP_SET_IN_W, 0, 127, 200);
		cmd(OP_SET_OUT_W, 0, 127, 255);
		cmd(OP_FIRE, 0, 0, 0);                // transition 2, plain fire
		cmd(OP_SET_TOKENS, 0, 0, 16'hAAAA);
		cmd(OP_SET_TOKENS, 64, 0, 16'h5555);
		cmd(OP_READ, 0, 0, 0);
		cmd(OP_READ, 64, 0, 0);
		cmd(3'd5, 127, 127, 16'hFFFF);
		cmd(3'd6, 1, 1, 1);
		cmd(3'd7, 0, 0, 0);
		cmd(OP_READ, 0, 0, 0);

		// zero acts as one: only place 0, transition 0
		set_sizes(0, 0);
		cmd(OP_SET_TOKENS, 1, 0, 9);          // ignored, out of range
		cmd(OP_READ, 1, 0, 0);
		cmd(OP_SET_IN_W, 0, 1, 3);            // ignored
		cmd(OP_FIRE, 0, 0, 0);
		repeat (8) random_beat();

		// above the maximum acts as the maximum
		set_sizes(255, 255);
		cmd(OP_SET_IN_W, 127, 127, 1);
		cmd(OP_READ, 127, 0, 0);
		repeat (4) random_beat();

		set_sizes(200, 2);
		repeat (20) random_beat();
		set_sizes(1, 128);
		repeat (20) random_beat();

		for (int ph = 0; ph < 13; ph++) begin
			np = $urandom_range(1, 8);
			nt = $urandom_range(1, 8);
			set_sizes(np, nt);
			repeat (58) random_beat();
		end
		in_valid <= 1'b0;
		@(posedge clk);

		while (sb.pending() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (sb.mismatches == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end
endmodule
